// File: rtl/locd_pkg.sv
`timescale 1ns / 1ps
package locd_pkg;

    localparam int ID_W            = 5;
    localparam int ID_COUNT        = 2 ** ID_W;
    localparam int DEF_MAX_LOCKS   = 32;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QP_W            = $clog2(QUEUE_DEPTH);
    localparam int QC_W            = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        K_ACQUIRE = 1'b0,
        K_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_DEADLOCK     = 3'd1,
        ST_MULTI_UNLOCK = 3'd2,
        ST_BAD_UNLOCK   = 3'd3,
        ST_OVERFLOW     = 3'd4
    } t_status;

    typedef struct packed {
        t_kind            kind;
        logic [ID_W-1:0]  lock_id;
    } t_cmd;

    typedef struct packed {
        t_status          status;
        logic             edge_added;
        logic [ID_W-1:0]  edge_from;
        logic [ID_W-1:0]  edge_to;
        logic             halted;
    } t_result;

endpackage

// File: rtl/locd_front.sv
`timescale 1ns / 1ps
module locd_front #(
    parameter int MAX_LOCKS = locd_pkg::DEF_MAX_LOCKS
) (
    input  logic                      push,
    output logic                      full,
    input  logic                      i_kind,
    input  logic [locd_pkg::ID_W-1:0] i_lock_id,
    input  logic                      i_q_full,
    output logic                      o_wr,
    output locd_pkg::t_cmd            o_cmd
);
    import locd_pkg::*;

    // lock id reduced modulo MAX_LOCKS
    logic [ID_W-1:0] w_mod_tbl [ID_COUNT];

    for (genvar g = 0; g < ID_COUNT; g++) begin : g_mod
        assign w_mod_tbl[g] = ID_W'(g % MAX_LOCKS);
    end

    assign full          = i_q_full;
    assign o_wr          = push && !i_q_full;
    assign o_cmd.kind    = t_kind'(i_kind);
    assign o_cmd.lock_id = w_mod_tbl[i_lock_id];

endmodule

// File: rtl/locd_queue.sv
`timescale 1ns / 1ps
module locd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  locd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output locd_pkg::t_cmd o_cmd
);
    import locd_pkg::*;

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wp;
    logic [QP_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;
    logic [QP_W-1:0] n_wp;
    logic [QP_W-1:0] n_rp;

    assign n_wp = (r_wp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= n_wp;
            end
            if (i_rd) begin
                r_rp <= n_rp;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

endmodule

// File: rtl/locd_back.sv
`timescale 1ns / 1ps
module locd_back #(
    parameter int MAX_LOCKS   = locd_pkg::DEF_MAX_LOCKS,
    parameter int STACK_DEPTH = locd_pkg::DEF_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  locd_pkg::t_cmd    i_cmd,
    output logic              empty,
    input  logic              pop,
    output locd_pkg::t_result o_res
);
    import locd_pkg::*;

    localparam int RW    = $clog2(MAX_LOCKS);
    localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_ROW,
        S_WALK
    } t_state;

    t_state                 r_state,    n_state;
    t_cmd                   r_cmd,      n_cmd;
    logic [CNT_W-1:0]       r_count,    n_count;
    logic                   r_halted,   n_halted;
    logic [ID_W-1:0]        r_top,      n_top;
    logic [MAX_LOCKS-1:0]   r_seen,     n_seen;
    logic [MAX_LOCKS-1:0]   r_pending,  n_pending;
    logic                   r_inflight, n_inflight;
    logic                   r_ovalid,   n_ovalid;
    t_result                r_res,      n_res;

    // held-lock stack
    logic [ID_W-1:0]        r_stk [STACK_DEPTH];
    logic [ID_W-1:0]        r_stk_rd;

    // lock-order matrix, one valid bit per row
    logic [MAX_LOCKS-1:0]   r_mtx [MAX_LOCKS];
    logic [MAX_LOCKS-1:0]   r_mvld;
    logic [MAX_LOCKS-1:0]   r_mrow;
    logic                   r_mrow_vld;

    logic                   w_take;
    logic                   w_push;
    logic                   w_mwr;
    logic [RW-1:0]          w_maddr;
    logic [RW-1:0]          w_id_row;
    logic [RW-1:0]          w_top_row;
    logic [MAX_LOCKS-1:0]   w_row;
    logic [MAX_LOCKS-1:0]   w_bit;
    logic [MAX_LOCKS-1:0]   w_lowest;
    logic [RW-1:0]          w_pick;
    logic                   w_res_fire;

    assign w_take    = (r_state == S_IDLE) && !i_q_empty && (!r_ovalid || pop);
    assign o_q_pop   = w_take;
    assign w_row     = r_mrow_vld ? r_mrow : '0;
    assign w_id_row  = RW'(r_cmd.lock_id);
    assign w_top_row = RW'(r_top);
    assign w_bit     = MAX_LOCKS'(1) << w_id_row;
    assign w_lowest  = r_pending & (~r_pending + MAX_LOCKS'(1));

    always_comb begin
        w_pick = '0;
        for (int i = 0; i < MAX_LOCKS; i++) begin
            if (w_lowest[i]) begin
                w_pick = w_pick | RW'(i);
            end
        end
    end

    always_comb begin
        logic [MAX_LOCKS-1:0] v_grow;
        logic [MAX_LOCKS-1:0] v_seen;
        t_status              v_status;
        logic                 v_edge;

        n_state    = r_state;
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_halted   = r_halted;
        n_top      = r_top;
        n_seen     = r_seen;
        n_pending  = r_pending;
        n_inflight = r_inflight;
        n_ovalid   = r_ovalid && !pop;
        n_res      = r_res;
        w_push     = 1'b0;
        w_mwr      = 1'b0;
        w_maddr    = w_pick;
        w_res_fire = 1'b0;
        v_status   = ST_OK;
        v_edge     = 1'b0;
        v_grow     = r_inflight ? (w_row & ~r_seen) : '0;
        v_seen     = r_seen | v_grow;

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_cmd   = i_cmd;
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                n_top   = r_stk_rd;
                w_maddr = RW'(r_stk_rd);
                if (r_halted) begin
                    w_res_fire = 1'b1;
                end else if (r_cmd.kind == K_RELEASE) begin
                    w_res_fire = 1'b1;
                    if (r_count == '0) begin
                        v_status = ST_MULTI_UNLOCK;
                    end else if (r_stk_rd != r_cmd.lock_id) begin
                        v_status = ST_BAD_UNLOCK;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end else if (r_count == CNT_W'(STACK_DEPTH)) begin
                    w_res_fire = 1'b1;
                    v_status   = ST_OVERFLOW;
                end else if (r_count == '0 || r_stk_rd == r_cmd.lock_id) begin
                    w_res_fire = 1'b1;
                    w_push     = 1'b1;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if ((w_row & w_bit) != '0) begin
                    w_res_fire = 1'b1;
                    w_push     = 1'b1;
                end else begin
                    w_mwr      = 1'b1;
                    n_seen     = w_bit;
                    n_pending  = w_bit;
                    n_inflight = 1'b0;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                n_seen = v_seen;
                if (r_pending != '0) begin
                    n_inflight = 1'b1;
                    n_pending  = (r_pending & ~w_lowest) | v_grow;
                end else begin
                    n_inflight = 1'b0;
                    n_pending  = v_grow;
                end
                if (v_seen[w_top_row]) begin
                    w_res_fire = 1'b1;
                    v_edge     = 1'b1;
                    v_status   = ST_DEADLOCK;
                end else if (r_pending == '0 && !r_inflight) begin
                    w_res_fire = 1'b1;
                    v_edge     = 1'b1;
                    w_push     = 1'b1;
                end
            end
        endcase

        if (w_push) begin
            n_count = r_count + 1'b1;
        end

        if (w_res_fire) begin
            n_state          = S_IDLE;
            n_ovalid         = 1'b1;
            n_halted         = r_halted || (v_status != ST_OK);
            n_res.status     = v_status;
            n_res.edge_added = v_edge;
            n_res.edge_from  = v_edge ? r_top : '0;
            n_res.edge_to    = v_edge ? r_cmd.lock_id : '0;
            n_res.halted     = n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_halted   <= 1'b0;
            r_inflight <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_halted   <= n_halted;
            r_inflight <= n_inflight;
            r_ovalid   <= n_ovalid;
        end
        r_cmd     <= n_cmd;
        r_top     <= n_top;
        r_seen    <= n_seen;
        r_pending <= n_pending;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stk[SP_W'(r_count)] <= r_cmd.lock_id;
        end
        r_stk_rd <= r_stk[SP_W'(r_count - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (w_mwr) begin
            r_mtx[w_top_row] <= w_row | w_bit;
        end
        r_mrow <= r_mtx[w_maddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld     <= '0;
            r_mrow_vld <= 1'b0;
        end else begin
            if (w_mwr) begin
                r_mvld[w_top_row] <= 1'b1;
            end
            r_mrow_vld <= r_mvld[w_maddr];
        end
    end

    assign empty = !r_ovalid;
    assign o_res = r_res;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_fire |-> !r_ovalid)
        else $error("result beat overwrites a waiting result");

    a_walk_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_pending & ~r_seen) == '0))
        else $error("walk frontier outside visited set");

endmodule

// File: rtl/lock_order_cycle_detector.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     push / full            i_kind, i_lock_id
// result    empty / pop            o_status, o_edge_added, o_edge_from, o_edge_to, o_halted
//
// A release, a repeat acquire or an acquire onto an empty stack finishes in the engine's S_TOP state.
// An acquire of a known edge finishes in S_ROW; a new edge adds a walk that issues one matrix row
// read per cycle and waits each time the frontier runs dry, through the single registered read
// port of the order matrix.
// Reset is synchronous; the matrix row valid bits clear at once, no clearing pass.
// A 2-beat queue takes input while the engine works or a result beat waits on pop.
module lock_order_cycle_detector #(
    parameter int MAX_LOCKS   = locd_pkg::DEF_MAX_LOCKS,
    parameter int STACK_DEPTH = locd_pkg::DEF_STACK_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_kind,
    input  logic [locd_pkg::ID_W-1:0] i_lock_id,
    output logic                      empty,
    input  logic                      pop,
    output logic [2:0]                o_status,
    output logic                      o_edge_added,
    output logic [locd_pkg::ID_W-1:0] o_edge_from,
    output logic [locd_pkg::ID_W-1:0] o_edge_to,
    output logic                      o_halted
);
    import locd_pkg::*;

    logic    w_q_full;
    logic    w_q_wr;
    t_cmd    w_q_in;
    logic    w_q_empty;
    logic    w_q_pop;
    t_cmd    w_q_out;
    t_result w_res;

    locd_front #(
        .MAX_LOCKS (MAX_LOCKS)
    ) u_front (
        .push      (push),
        .full      (full),
        .i_kind    (i_kind),
        .i_lock_id (i_lock_id),
        .i_q_full  (w_q_full),
        .o_wr      (w_q_wr),
        .o_cmd     (w_q_in)
    );

    locd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_cmd   (w_q_in),
        .o_full  (w_q_full),
        .i_rd    (w_q_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_q_out)
    );

    locd_back #(
        .MAX_LOCKS   (MAX_LOCKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_cmd     (w_q_out),
        .empty     (empty),
        .pop       (pop),
        .o_res     (w_res)
    );

    assign o_status     = w_res.status;
    assign o_edge_added = w_res.edge_added;
    assign o_edge_from  = w_res.edge_from;
    assign o_edge_to    = w_res.edge_to;
    assign o_halted     = w_res.halted;

endmodule
